### rtl/smeu_pkg.sv
package smeu_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int WORD_BITS   = 32;
   localparam int ADDR_BITS   = $clog2(STACK_DEPTH);
   localparam int PTR_BITS    = ADDR_BITS + 1;
   localparam int CMD_BITS    = 5;
   localparam int LIT_BITS    = 32;
   localparam int OUT_BITS    = 32;
   localparam int IDX_BITS    = 7;
   localparam int DIV_CNT_BITS = $clog2(WORD_BITS + 1);

   typedef enum logic [CMD_BITS-1:0] {
      CMD_PUSH      = 5'd0,
      CMD_PUSH_IDX  = 5'd1,
      CMD_ADD       = 5'd2,
      CMD_SUB       = 5'd3,
      CMD_MUL       = 5'd4,
      CMD_DIV       = 5'd5,
      CMD_MOD       = 5'd6,
      CMD_NOT       = 5'd7,
      CMD_AND       = 5'd8,
      CMD_OR        = 5'd9,
      CMD_XOR       = 5'd10,
      CMD_LT        = 5'd11,
      CMD_GT        = 5'd12,
      CMD_EQ        = 5'd13,
      CMD_DUP       = 5'd14,
      CMD_DROP      = 5'd15,
      CMD_PRINTNUM  = 5'd16,
      CMD_PRINTCHAR = 5'd17,
      CMD_REVERSE   = 5'd18
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_UNDERFLOW = 2'd1,
      ST_OVERFLOW  = 2'd2,
      ST_DIV_ZERO  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CLS_NOP,
      CLS_PUSH,
      CLS_UNARY,
      CLS_BINARY
   } class_type;

   typedef struct packed {
      logic [CMD_BITS-1:0] command;
      logic [LIT_BITS-1:0] literal;
      class_type           op_class;
   } op_type;

   typedef enum logic [3:0] {
      EX_IDLE,
      EX_READ_TOP,
      EX_READ_SECOND,
      EX_EXEC,
      EX_WRITE_RES,
      EX_DIVIDE,
      EX_DIV_DONE,
      EX_REV_READ_LO,
      EX_REV_READ_HI,
      EX_REV_WRITE,
      EX_REV_WRITE_HI,
      EX_READ_NEW_TOP,
      EX_OUTPUT
   } ex_state_type;

endpackage

### rtl/smeu_front.sv
module smeu_front
   import smeu_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [CMD_BITS-1:0] in_command,
   input  logic [LIT_BITS-1:0] in_literal,
   output logic                q_valid,
   input  logic                q_ready,
   output op_type              q_op
);

   op_type     entry_ff [2];
   op_type     entry_in;
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push, pop;

   always_comb begin
      entry_in.command = in_command;
      entry_in.literal = in_literal;
      if (in_command inside {CMD_PUSH, CMD_PUSH_IDX, CMD_DUP}) begin
         entry_in.op_class = CLS_PUSH;
      end else if (in_command inside {[CMD_ADD:CMD_EQ]} && in_command != CMD_NOT) begin
         entry_in.op_class = CLS_BINARY;
      end else if (in_command inside {CMD_NOT, [CMD_DROP:CMD_REVERSE]}) begin
         entry_in.op_class = CLS_UNARY;
      end else begin
         entry_in.op_class = CLS_NOP;
      end
   end

   assign in_ready = (count_ff != 2'd2);
   assign q_valid  = (count_ff != 2'd0);
   assign q_op     = entry_ff[rd_ptr_ff];
   assign push     = in_valid && in_ready;
   assign pop      = q_valid && q_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= entry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

### rtl/smeu_back.sv
module smeu_back
   import smeu_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   output logic                q_ready,
   input  op_type              q_op,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [OUT_BITS-1:0] out_top_value,
   output logic [IDX_BITS-1:0] out_top_index,
   output logic                out_emit_valid,
   output logic                out_emit_is_char,
   output logic [OUT_BITS-1:0] out_emit_value,
   output status_type          out_status
);

   localparam logic [PTR_BITS-1:0] PTR_EMPTY = '1;

   logic [WORD_BITS-1:0] mem [STACK_DEPTH];
   logic [STACK_DEPTH-1:0] vld_ff;
   logic [WORD_BITS-1:0] rd_data_raw;
   logic [ADDR_BITS-1:0] rd_addr_ff;
   logic                 wr_en;
   logic [ADDR_BITS-1:0] wr_addr;
   logic [WORD_BITS-1:0] wr_data;
   logic [WORD_BITS-1:0] rd_data;
   logic                 rd_en;
   logic [ADDR_BITS-1:0] rd_addr;

   ex_state_type state_ff, state_in;
   op_type       op_ff;
   logic [PTR_BITS-1:0]  tp_ff, tp_in;
   logic [WORD_BITS-1:0] a_ff, a_in, b_ff, b_in;
   logic [WORD_BITS-1:0] res_ff, res_in;
   status_type           st_ff, st_in;
   logic                 ev_ff, ev_in, ec_ff, ec_in;
   logic [WORD_BITS-1:0] evl_ff, evl_in;
   logic [PTR_BITS-1:0]  lo_ff, lo_in, hi_ff, hi_in;
   logic [WORD_BITS-1:0] rem_ff, rem_in, quo_ff, quo_in, dvd_ff, dvd_in, dvs_ff, dvs_in;
   logic [DIV_CNT_BITS-1:0] dcnt_ff, dcnt_in;
   logic                 ovalid_ff;
   logic [WORD_BITS-1:0] otop_ff;
   logic [PTR_BITS-1:0]  otp_ff;
   logic                 oev_ff, oec_ff;
   logic [WORD_BITS-1:0] oevl_ff;
   status_type           ost_ff;
   logic                 load_out;

   logic [PTR_BITS-1:0]  count;
   logic [2*WORD_BITS-1:0] prod;
   logic [WORD_BITS:0]   rem_shift;
   logic [WORD_BITS:0]   rem_sub;
   logic                 a_neg, b_neg;
   logic [PTR_BITS-1:0]  left;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_raw <= mem[rd_addr];
         rd_addr_ff  <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_data = vld_ff[rd_addr_ff] ? rd_data_raw : '0;
   assign count   = tp_ff + 1'b1;
   assign a_neg   = a_ff[WORD_BITS-1];
   assign b_neg   = b_ff[WORD_BITS-1];
   assign left    = tp_ff;
   assign prod    = a_ff * b_ff;
   assign rem_shift = {rem_ff, dvd_ff[WORD_BITS-1]};
   assign rem_sub   = rem_shift - {1'b0, dvs_ff};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         EX_IDLE: begin
            if (q_valid) begin
               state_in = EX_READ_TOP;
            end
         end
         EX_READ_TOP: begin
            state_in = EX_EXEC;
            if (op_ff.op_class == CLS_BINARY && count >= PTR_BITS'(2)) begin
               state_in = EX_READ_SECOND;
            end
         end
         EX_READ_SECOND: state_in = EX_EXEC;
         EX_EXEC: begin
            state_in = EX_READ_NEW_TOP;
            if (op_ff.op_class == CLS_BINARY && st_in != ST_UNDERFLOW) begin
               state_in = EX_WRITE_RES;
               if (st_in == ST_OK && op_ff.command inside {CMD_DIV, CMD_MOD}) begin
                  state_in = EX_DIVIDE;
               end
            end else if (st_in == ST_OK && op_ff.command == CMD_REVERSE
                         && $signed(lo_in) < $signed(hi_in)) begin
               state_in = EX_REV_READ_LO;
            end
         end
         EX_WRITE_RES: state_in = EX_READ_NEW_TOP;
         EX_DIVIDE: begin
            if (dcnt_ff == DIV_CNT_BITS'(1)) begin
               state_in = EX_DIV_DONE;
            end
         end
         EX_DIV_DONE: state_in = EX_READ_NEW_TOP;
         EX_REV_READ_LO: state_in = EX_REV_READ_HI;
         EX_REV_READ_HI: state_in = EX_REV_WRITE;
         EX_REV_WRITE: state_in = EX_REV_WRITE_HI;
         EX_REV_WRITE_HI: begin
            state_in = EX_READ_NEW_TOP;
            if (lo_ff + 1'b1 < hi_ff - 1'b1) begin
               state_in = EX_REV_READ_LO;
            end
         end
         EX_READ_NEW_TOP: state_in = EX_OUTPUT;
         EX_OUTPUT: begin
            if (!ovalid_ff || out_ready) begin
               state_in = EX_IDLE;
            end
         end
         default: state_in = EX_IDLE;
      endcase
   end

   always_comb begin
      q_ready  = (state_ff == EX_IDLE);
      rd_en    = 1'b0;
      rd_addr  = tp_ff[ADDR_BITS-1:0];
      wr_en    = 1'b0;
      wr_addr  = tp_ff[ADDR_BITS-1:0];
      wr_data  = '0;
      tp_in    = tp_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      res_in   = res_ff;
      st_in    = st_ff;
      ev_in    = ev_ff;
      ec_in    = ec_ff;
      evl_in   = evl_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvd_in   = dvd_ff;
      dvs_in   = dvs_ff;
      dcnt_in  = dcnt_ff;
      load_out = 1'b0;
      case (state_ff)
         EX_IDLE: begin
            st_in = ST_OK;
            ev_in = 1'b0;
            ec_in = 1'b0;
            evl_in = '0;
            rd_en = 1'b1;
         end
         EX_READ_TOP: begin
            b_in    = rd_data;
            rd_en   = 1'b1;
            rd_addr = tp_ff[ADDR_BITS-1:0] - 1'b1;
         end
         EX_READ_SECOND: begin
            a_in = rd_data;
         end
         EX_EXEC: begin
            case (op_ff.op_class)
               CLS_PUSH: begin
                  if (op_ff.command == CMD_DUP && tp_ff == PTR_EMPTY) begin
                     st_in = ST_UNDERFLOW;
                  end else if (!tp_ff[PTR_BITS-1] && tp_ff >= PTR_BITS'(STACK_DEPTH - 1)) begin
                     st_in = ST_OVERFLOW;
                  end else begin
                     wr_en   = 1'b1;
                     wr_addr = count[ADDR_BITS-1:0];
                     if (op_ff.command == CMD_PUSH) begin
                        wr_data = WORD_BITS'($signed(op_ff.literal));
                     end else if (op_ff.command == CMD_PUSH_IDX) begin
                        wr_data = WORD_BITS'(count);
                     end else begin
                        wr_data = b_ff;
                     end
                     tp_in = count;
                  end
               end
               CLS_BINARY: begin
                  if (tp_ff[PTR_BITS-1] || tp_ff == '0) begin
                     st_in = ST_UNDERFLOW;
                  end else begin
                     wr_en = 1'b1;
                     wr_data = '0;
                     tp_in = tp_ff - 1'b1;
                     case (op_ff.command)
                        CMD_ADD: res_in = a_ff + b_ff;
                        CMD_SUB: res_in = a_ff - b_ff;
                        CMD_MUL: res_in = prod[WORD_BITS-1:0];
                        CMD_AND: res_in = WORD_BITS'(a_ff != '0 && b_ff != '0);
                        CMD_OR:  res_in = WORD_BITS'(a_ff != '0 || b_ff != '0);
                        CMD_XOR: res_in = WORD_BITS'((a_ff != '0) != (b_ff != '0));
                        CMD_LT:  res_in = WORD_BITS'($signed(a_ff) < $signed(b_ff));
                        CMD_GT:  res_in = WORD_BITS'($signed(b_ff) < $signed(a_ff));
                        CMD_EQ:  res_in = WORD_BITS'(a_ff == b_ff);
                        default: begin
                           res_in = '0;
                           if (b_ff == '0) begin
                              st_in = ST_DIV_ZERO;
                           end
                           dvd_in  = a_neg ? -a_ff : a_ff;
                           dvs_in  = b_neg ? -b_ff : b_ff;
                           rem_in  = '0;
                           quo_in  = '0;
                           dcnt_in = DIV_CNT_BITS'(WORD_BITS);
                        end
                     endcase
                  end
               end
               CLS_UNARY: begin
                  if (tp_ff[PTR_BITS-1]) begin
                     st_in = ST_UNDERFLOW;
                  end else if (op_ff.command == CMD_NOT) begin
                     wr_en   = 1'b1;
                     wr_data = WORD_BITS'(b_ff == '0);
                  end else if (op_ff.command == CMD_REVERSE) begin
                     if (!b_neg && b_ff > WORD_BITS'(left)) begin
                        st_in = ST_UNDERFLOW;
                     end else begin
                        wr_en = 1'b1;
                        tp_in = tp_ff - 1'b1;
                        hi_in = tp_ff - 1'b1;
                        lo_in = b_neg ? tp_ff : tp_ff - PTR_BITS'(b_ff);
                     end
                  end else begin
                     wr_en = 1'b1;
                     tp_in = tp_ff - 1'b1;
                     if (op_ff.command != CMD_DROP) begin
                        ev_in  = 1'b1;
                        ec_in  = (op_ff.command == CMD_PRINTCHAR);
                        evl_in = b_ff;
                     end
                  end
               end
               default: ;
            endcase
         end
         EX_WRITE_RES: begin
            wr_en   = 1'b1;
            wr_data = res_ff;
         end
         EX_DIVIDE: begin
            dvd_in = {dvd_ff[WORD_BITS-2:0], 1'b0};
            if (!rem_sub[WORD_BITS]) begin
               rem_in = rem_sub[WORD_BITS-1:0];
               quo_in = {quo_ff[WORD_BITS-2:0], 1'b1};
            end else begin
               rem_in = rem_shift[WORD_BITS-1:0];
               quo_in = {quo_ff[WORD_BITS-2:0], 1'b0};
            end
            dcnt_in = dcnt_ff - 1'b1;
         end
         EX_DIV_DONE: begin
            wr_en   = 1'b1;
            if (op_ff.command == CMD_DIV) begin
               wr_data = (a_neg != b_neg) ? -quo_ff : quo_ff;
            end else begin
               wr_data = a_neg ? -rem_ff : rem_ff;
            end
         end
         EX_REV_READ_LO: begin
            rd_en   = 1'b1;
            rd_addr = lo_ff[ADDR_BITS-1:0];
         end
         EX_REV_READ_HI: begin
            a_in    = rd_data;
            rd_en   = 1'b1;
            rd_addr = hi_ff[ADDR_BITS-1:0];
         end
         EX_REV_WRITE: begin
            b_in    = rd_data;
            wr_en   = 1'b1;
            wr_addr = lo_ff[ADDR_BITS-1:0];
            wr_data = rd_data;
         end
         EX_REV_WRITE_HI: begin
            wr_en   = 1'b1;
            wr_addr = hi_ff[ADDR_BITS-1:0];
            wr_data = a_ff;
            lo_in   = lo_ff + 1'b1;
            hi_in   = hi_ff - 1'b1;
         end
         EX_READ_NEW_TOP: begin
            rd_en = 1'b1;
         end
         EX_OUTPUT: begin
            load_out = (!ovalid_ff || out_ready);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (q_valid && q_ready) begin
         op_ff <= q_op;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      res_ff <= res_in;
      st_ff  <= st_in;
      ev_ff  <= ev_in;
      ec_ff  <= ec_in;
      evl_ff <= evl_in;
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      dcnt_ff <= dcnt_in;
      if (load_out) begin
         otop_ff <= tp_ff[PTR_BITS-1] ? '0 : rd_data;
         otp_ff  <= tp_ff;
         oev_ff  <= ev_ff;
         oec_ff  <= ec_ff;
         oevl_ff <= evl_ff;
         ost_ff  <= st_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= EX_IDLE;
         tp_ff     <= PTR_EMPTY;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         tp_ff    <= tp_in;
         if (load_out) begin
            ovalid_ff <= 1'b1;
         end else if (out_ready) begin
            ovalid_ff <= 1'b0;
         end
      end
   end

   assign out_valid        = ovalid_ff;
   assign out_top_value    = OUT_BITS'(otop_ff);
   assign out_top_index    = IDX_BITS'($signed(otp_ff));
   assign out_emit_valid   = oev_ff;
   assign out_emit_is_char = oec_ff;
   assign out_emit_value   = OUT_BITS'(oevl_ff);
   assign out_status       = ost_ff;

endmodule

### rtl/stack_machine_execute_unit.sv
// Channel  Direction  Contents
// req_     in         tdata: command, literal
// rsp_     out        tdata: top_value, top_index, emit fields, status
//
// The execute loop reads the top word, and for add through eq also the second if present,
// executes, then reads the new top and loads the result. Add through eq, a zero divisor
// included, first write their result; divide and modulo with a nonzero divisor first run a
// serial divider. Reverse reads and then writes each swapped pair, one pair at a time.
// A held result stalls the back end only when the next result is ready to load.
// Reset is synchronous and empties the stack; slot valid bits make every slot read zero.
// A two-entry queue decouples request acceptance from execution.
module stack_machine_execute_unit
   import smeu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // command [4:0], literal [36:5], zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata    // top_value, top_index, emit_valid, emit_is_char,
                                    // emit_value, status, zero fill
);

   logic   q_valid, q_ready;
   op_type q_op;
   logic [OUT_BITS-1:0] top_value, emit_value;
   logic [IDX_BITS-1:0] top_index;
   logic                emit_valid, emit_is_char;
   status_type          status;

   smeu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_command (req_tdata[4:0]),
      .in_literal (req_tdata[36:5]),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_op       (q_op)
   );

   smeu_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_ready          (q_ready),
      .q_op             (q_op),
      .out_valid        (rsp_tvalid),
      .out_ready        (rsp_tready),
      .out_top_value    (top_value),
      .out_top_index    (top_index),
      .out_emit_valid   (emit_valid),
      .out_emit_is_char (emit_is_char),
      .out_emit_value   (emit_value),
      .out_status       (status)
   );

   assign rsp_tdata = {5'd0, status, emit_value, emit_is_char, emit_valid, top_index, top_value};

endmodule

### bench/tb_stack_machine_execute_unit.sv
`timescale 1ns / 1ps

module tb_stack_machine_execute_unit;
   import smeu_pkg::*;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] emit_value;
      logic        emit_is_char;
      logic        emit_valid;
      logic [6:0]  top_index;
      logic [31:0] top_value;
   } outcome_type;

   typedef struct {
      logic [4:0]  cmd;
      logic [31:0] lit;
      logic        known;
      outcome_type want;
   } vector_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [79:0] rsp_tdata;

   logic [31:0] stack_words [0:STACK_DEPTH-1];
   int          top_ptr;
   outcome_type pending_outcomes [$];
   int          mismatch_count;
   int          outcome_count;
   int          emit_count;
   int          refused_count;
   bit          stim_done;
   vector_type  vectors [$];

   stack_machine_execute_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic logic [31:0] pop_word();
      logic [31:0] v;
      v = stack_words[top_ptr];
      stack_words[top_ptr] = '0;
      top_ptr--;
      return v;
   endfunction

   function automatic outcome_type execute_command(logic [4:0] cmd, logic [31:0] lit);
      outcome_type o;
      int          cnt;
      logic [31:0] a, b, r, ma, mb, t;
      int          n, lo, hi;
      o = '0;
      cnt = top_ptr + 1;
      if (cmd == CMD_PUSH || cmd == CMD_PUSH_IDX || cmd == CMD_DUP) begin
         if (cmd == CMD_DUP && cnt < 1) begin
            o.status = ST_UNDERFLOW;
         end else if (cnt >= STACK_DEPTH) begin
            o.status = ST_OVERFLOW;
         end else begin
            if (cmd == CMD_PUSH) r = lit;
            else if (cmd == CMD_PUSH_IDX) r = 32'(top_ptr + 1);
            else r = stack_words[top_ptr];
            top_ptr++;
            stack_words[top_ptr] = r;
         end
      end else if (cmd >= CMD_ADD && cmd <= CMD_EQ && cmd != CMD_NOT) begin
         if (cnt < 2) begin
            o.status = ST_UNDERFLOW;
         end else begin
            b = pop_word();
            a = stack_words[top_ptr];
            r = '0;
            case (cmd)
               CMD_ADD: r = a + b;
               CMD_SUB: r = a - b;
               CMD_MUL: r = a * b;
               CMD_DIV, CMD_MOD: begin
                  if (b == 0) begin
                     o.status = ST_DIV_ZERO;
                  end else begin
                     ma = a[31] ? -a : a;
                     mb = b[31] ? -b : b;
                     if (cmd == CMD_DIV) r = (a[31] != b[31]) ? -(ma / mb) : ma / mb;
                     else r = a[31] ? -(ma % mb) : ma % mb;
                  end
               end
               CMD_AND: r = 32'(a != 0 && b != 0);
               CMD_OR:  r = 32'(a != 0 || b != 0);
               CMD_XOR: r = 32'((a != 0) != (b != 0));
               CMD_LT:  r = 32'($signed(a) < $signed(b));
               CMD_GT:  r = 32'($signed(b) < $signed(a));
               default: r = 32'(a == b);
            endcase
            stack_words[top_ptr] = r;
         end
      end else if (cmd == CMD_NOT) begin
         if (cnt < 1) o.status = ST_UNDERFLOW;
         else stack_words[top_ptr] = 32'(stack_words[top_ptr] == 0);
      end else if (cmd == CMD_DROP || cmd == CMD_PRINTNUM || cmd == CMD_PRINTCHAR) begin
         if (cnt < 1) begin
            o.status = ST_UNDERFLOW;
         end else begin
            r = pop_word();
            if (cmd != CMD_DROP) begin
               o.emit_valid = 1'b1;
               o.emit_is_char = (cmd == CMD_PRINTCHAR);
               o.emit_value = r;
            end
         end
      end else if (cmd == CMD_REVERSE) begin
         if (cnt < 1) begin
            o.status = ST_UNDERFLOW;
         end else begin
            a = stack_words[top_ptr];
            if (!a[31] && a > 32'(cnt - 1)) begin
               o.status = ST_UNDERFLOW;
            end else begin
               n = a[31] ? 0 : int'(a);
               void'(pop_word());
               hi = top_ptr;
               lo = top_ptr - n + 1;
               while (n > 1 && lo < hi) begin
                  t = stack_words[lo];
                  stack_words[lo] = stack_words[hi];
                  stack_words[hi] = t;
                  lo++;
                  hi--;
               end
            end
         end
      end
      o.top_value = (top_ptr >= 0) ? stack_words[top_ptr] : '0;
      o.top_index = 7'(top_ptr);
      return o;
   endfunction

   task automatic send_command(logic [4:0] cmd, logic [31:0] lit, bit known,
                               outcome_type want);
      outcome_type o;
      int          gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {3'b000, lit, cmd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      o = execute_command(cmd, lit);
      if (known && o != want) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("Predictor disagrees with table: cmd %0d expected %h got %h",
                     cmd, want, o);
      end
      pending_outcomes.push_back(known ? want : o);
      if (o.emit_valid) emit_count++;
      if (o.status != ST_OK) refused_count++;
      @(negedge clock);
   endtask

   function automatic outcome_type mk(logic [31:0] tv, int ti, logic [1:0] st);
      outcome_type o;
      o = '0;
      o.top_value = tv;
      o.top_index = 7'(ti);
      o.status = st;
      return o;
   endfunction

   task automatic add_row(logic [4:0] cmd, logic [31:0] lit, bit known, outcome_type want);
      vector_type v;
      v.cmd = cmd;
      v.lit = lit;
      v.known = known;
      v.want = want;
      vectors.push_back(v);
   endtask

   always @(posedge clock) begin
      outcome_type got, exp;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[74:0];
         outcome_count++;
         if (pending_outcomes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("Unexpected transaction: %h", got);
         end else begin
            exp = pending_outcomes.pop_front();
            if (got != exp) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("Mismatch: expected tv %h ti %0d ev %b ec %b evl %h st %0d,",
                     exp.top_value, exp.top_index, exp.emit_valid, exp.emit_is_char,
                     exp.emit_value, exp.status);
                  $display("          got tv %h ti %0d ev %b ec %b evl %h st %0d",
                     got.top_value, got.top_index, got.emit_valid, got.emit_is_char,
                     got.emit_value, got.status);
               end
            end
         end
      end
   end

   initial begin
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat (($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3))
               @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end
      end
   end

   initial begin
      #20000000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      int       k, depth, r;
      logic [4:0] cmd;
      logic [31:0] lit;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      mismatch_count = 0;
      outcome_count = 0;
      emit_count = 0;
      refused_count = 0;
      stim_done = 0;
      for (k = 0; k < STACK_DEPTH; k++) stack_words[k] = '0;
      top_ptr = -1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      add_row(CMD_DROP, 0, 1, mk(0, -1, ST_UNDERFLOW));
      add_row(CMD_REVERSE, 0, 1, mk(0, -1, ST_UNDERFLOW));
      add_row(CMD_ADD, 0, 1, mk(0, -1, ST_UNDERFLOW));
      add_row(CMD_PUSH, 32'h8000_0000, 1, mk(32'h8000_0000, 0, ST_OK));
      add_row(CMD_NOT, 0, 1, mk(0, 0, ST_OK));
      add_row(CMD_PUSH, 32'h7fff_ffff, 1, mk(32'h7fff_ffff, 1, ST_OK));
      add_row(CMD_PUSH_IDX, 0, 1, mk(2, 2, ST_OK));
      add_row(CMD_MUL, 0, 0, '0);
      add_row(CMD_PUSH, 32'h8000_0000, 0, '0);
      add_row(CMD_PUSH, 32'hffff_ffff, 0, '0);
      add_row(CMD_DIV, 0, 0, '0);
      add_row(CMD_PUSH, 32'hffff_ffff, 0, '0);
      add_row(CMD_MOD, 0, 0, '0);
      add_row(CMD_PUSH, 0, 0, '0);
      add_row(CMD_DIV, 0, 0, '0);
      add_row(CMD_PUSH, 0, 0, '0);
      add_row(CMD_MOD, 0, 0, '0);
      add_row(CMD_PUSH, 32'h0000_0041, 0, '0);
      add_row(CMD_PRINTCHAR, 0, 0, '0);
      add_row(CMD_PRINTNUM, 0, 0, '0);
      add_row(CMD_PUSH, 32'hffff_ffff, 0, '0);
      add_row(CMD_REVERSE, 0, 0, '0);
      add_row(5'd31, 32'hffff_ffff, 0, '0);
      add_row(5'd19, 0, 0, '0);
      foreach (vectors[i]) send_command(vectors[i].cmd, vectors[i].lit, vectors[i].known,
                                        vectors[i].want);

      // Fill to overflow and exercise long reverses at full depth.
      for (k = 0; k < STACK_DEPTH + 2; k++) send_command(CMD_PUSH_IDX, 0, 0, '0);
      send_command(CMD_DUP, 0, 0, '0);
      send_command(CMD_DROP, 0, 0, '0);
      send_command(CMD_PUSH, 62, 0, '0);
      send_command(CMD_REVERSE, 0, 0, '0);
      send_command(CMD_PUSH, 63, 0, '0);
      send_command(CMD_REVERSE, 0, 0, '0);
      while (top_ptr >= 0) send_command(CMD_DROP, 0, 0, '0);

      for (k = 0; k < 850; k++) begin
         depth = top_ptr + 1;
         r = $urandom_range(0, 99);
         lit = $urandom();
         case ($urandom_range(0, 3))
            0: lit = $urandom_range(0, 8);
            1: lit = -$urandom_range(0, 3);
            default: ;
         endcase
         if (depth < 3 && r < 60) cmd = CMD_PUSH;
         else if (depth > 50 && r < 40) cmd = CMD_DROP;
         else if (r < 3) cmd = 5'($urandom_range(19, 31));
         else if (r < 10 && depth > 0) begin
            send_command(CMD_PUSH, $urandom_range(0, depth), 0, '0);
            cmd = CMD_REVERSE;
         end else cmd = 5'($urandom_range(0, 18));
         send_command(cmd, lit, 0, '0);
      end
      req_tvalid <= 1'b0;
      stim_done = 1;
   end

   initial begin
      int w;
      wait (stim_done);
      w = 0;
      while (pending_outcomes.size() != 0 && w < 200000) begin
         @(posedge clock);
         w++;
      end
      repeat (400) @(posedge clock);
      $display("Checked %0d transactions: %0d emits, %0d refused or div-by-zero.",
               outcome_count, emit_count, refused_count);
      if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("%0d mismatches, %0d outstanding", mismatch_count,
                  pending_outcomes.size());
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

### sim.f
rtl/smeu_pkg.sv
rtl/smeu_front.sv
rtl/smeu_back.sv
rtl/stack_machine_execute_unit.sv
bench/tb_stack_machine_execute_unit.sv
